FILE: src/ddcc_pkg.sv
// Shared types, constants and month tables for the date / day-count converter.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package ddcc_pkg;

    // Operation codes
    localparam logic OP_TO_SERIAL = 1'b0;
    localparam logic OP_TO_DATE   = 1'b1;

    // Pipeline shape: both directions take PIPE_DEPTH register stages,
    // the top level adds its output register.
    localparam int unsigned PIPE_DEPTH = 7;
    localparam int unsigned FWD_STAGES = 4;
    localparam int unsigned LATENCY    = PIPE_DEPTH + 1;

    // Calendar constants
    localparam logic [13:0] YEAR_BASE  = 14'd2000;
    localparam logic [13:0] YEAR_MAX   = 14'd9999;
    localparam logic [3:0]  MONTHS     = 4'd12;
    localparam logic [3:0]  MONTH_FEB  = 4'd2;
    localparam logic [21:0] DAYS_MAX   = 22'd2921939;
    localparam logic [16:0] SECS_DAY   = 17'd86400;

    typedef struct packed {
        logic [21:0] days;
        logic [16:0] seconds;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        range_error;
    } t_result;

    // Day of the year on which a month starts (non-leap), index 0 = January
    function automatic logic [8:0] month_start_f(input logic [3:0] idx);
        logic [8:0] v;
        unique case (idx)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd59;
            4'd3:    v = 9'd90;
            4'd4:    v = 9'd120;
            4'd5:    v = 9'd151;
            4'd6:    v = 9'd181;
            4'd7:    v = 9'd212;
            4'd8:    v = 9'd243;
            4'd9:    v = 9'd273;
            4'd10:   v = 9'd304;
            4'd11:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // Month length (non-leap), index 0 = January
    function automatic logic [4:0] month_days_f(input logic [3:0] idx);
        logic [4:0] v;
        unique case (idx)
            4'd1:                                v = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:             v = 5'd30;
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9,
            4'd11:                               v = 5'd31;
            default:                             v = 5'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: src/ddcc_to_serial.sv
// Date and time to day count: four working stages, then a delay line to
// match the depth of the reverse path. Uses ddcc_pkg.
`default_nettype none

module ddcc_to_serial (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic [13:0]        i_year,
    input  wire logic [3:0]         i_month,
    input  wire logic [4:0]         i_day,
    input  wire logic [4:0]         i_hour,
    input  wire logic [5:0]         i_minute,
    input  wire logic [5:0]         i_second,
    output logic                    o_valid,
    output ddcc_pkg::t_result       o_result
);

    // x / 100 as (x * M100) >> K100, exact for 13-bit x
    localparam int unsigned K100 = 20;
    localparam logic [13:0] M100 = 14'(((32'd1 << K100) + 32'd99) / 32'd100);
    localparam int unsigned DLY  = ddcc_pkg::PIPE_DEPTH - ddcc_pkg::FWD_STAGES;

    // ---- stage 1: field checks, offsets, second of day
    logic        r_s1_v;
    logic        r_s1_err;
    logic [12:0] r_s1_dy;
    logic [3:0]  r_s1_mo;
    logic [4:0]  r_s1_dd;
    logic [4:0]  r_s1_hh;
    logic [5:0]  r_s1_mi;
    logic [5:0]  r_s1_ss;
    logic [13:0] r_s1_yr;
    logic [16:0] r_s1_secs;
    logic [8:0]  r_s1_mstart;
    logic [4:0]  r_s1_mdays;
    logic        n_s1_err;
    logic [16:0] n_s1_secs;
    logic [3:0]  w_midx;

    always_comb begin
        n_s1_err  = (i_year < ddcc_pkg::YEAR_BASE) || (i_year > ddcc_pkg::YEAR_MAX) ||
                    (i_month == 4'd0) || (i_month > ddcc_pkg::MONTHS) ||
                    (i_hour > 5'd23) || (i_minute > 6'd59) || (i_second > 6'd59);
        n_s1_secs = 17'(17'(i_hour) * 17'd3600 + 17'(i_minute) * 17'd60 + 17'(i_second));
        w_midx    = 4'(i_month - 4'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_err    <= n_s1_err;
        r_s1_dy     <= 13'(i_year - ddcc_pkg::YEAR_BASE);
        r_s1_mo     <= i_month;
        r_s1_dd     <= i_day;
        r_s1_hh     <= i_hour;
        r_s1_mi     <= i_minute;
        r_s1_ss     <= i_second;
        r_s1_yr     <= i_year;
        r_s1_secs   <= n_s1_secs;
        r_s1_mstart <= ddcc_pkg::month_start_f(w_midx);
        r_s1_mdays  <= ddcc_pkg::month_days_f(w_midx);
    end

    // ---- stage 2: divide by 100, 365 days a year
    logic        r_s2_v;
    logic        r_s2_err;
    logic [12:0] r_s2_dy;
    logic [6:0]  r_s2_dq;
    logic [6:0]  r_s2_pq;
    logic [21:0] r_s2_d365;
    logic [3:0]  r_s2_mo;
    logic [4:0]  r_s2_dd;
    logic [4:0]  r_s2_hh;
    logic [5:0]  r_s2_mi;
    logic [5:0]  r_s2_ss;
    logic [13:0] r_s2_yr;
    logic [16:0] r_s2_secs;
    logic [8:0]  r_s2_mstart;
    logic [4:0]  r_s2_mdays;
    logic [26:0] w_dq_prod;
    logic [26:0] w_pq_prod;

    always_comb begin
        w_dq_prod = 27'(r_s1_dy) * 27'(M100);
        w_pq_prod = 27'(13'(r_s1_dy - 13'd1)) * 27'(M100);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_err    <= r_s1_err;
        r_s2_dy     <= r_s1_dy;
        r_s2_dq     <= w_dq_prod[K100 +: 7];
        r_s2_pq     <= w_pq_prod[K100 +: 7];
        r_s2_d365   <= 22'(22'(r_s1_dy) * 22'd365);
        r_s2_mo     <= r_s1_mo;
        r_s2_dd     <= r_s1_dd;
        r_s2_hh     <= r_s1_hh;
        r_s2_mi     <= r_s1_mi;
        r_s2_ss     <= r_s1_ss;
        r_s2_yr     <= r_s1_yr;
        r_s2_secs   <= r_s1_secs;
        r_s2_mstart <= r_s1_mstart;
        r_s2_mdays  <= r_s1_mdays;
    end

    // ---- stage 3: leap flag, leap days before the year
    logic        r_s3_v;
    logic        r_s3_err;
    logic        r_s3_leap;
    logic [10:0] r_s3_leaps;
    logic [21:0] r_s3_d365;
    logic [3:0]  r_s3_mo;
    logic [4:0]  r_s3_dd;
    logic [4:0]  r_s3_hh;
    logic [5:0]  r_s3_mi;
    logic [5:0]  r_s3_ss;
    logic [13:0] r_s3_yr;
    logic [16:0] r_s3_secs;
    logic [8:0]  r_s3_mstart;
    logic [4:0]  r_s3_mdays;
    logic [6:0]  w_rem100;
    logic [12:0] w_p;
    logic        n_s3_leap;
    logic [10:0] n_s3_leaps;

    always_comb begin
        w_rem100   = 7'(r_s2_dy - 13'(13'(r_s2_dq) * 13'd100));
        // years counted from a 400-year boundary, so dy carries the leap rule
        n_s3_leap  = (r_s2_dy[1:0] == 2'd0) &&
                     ((w_rem100 != 7'd0) || (r_s2_dq[1:0] == 2'd0));
        w_p        = 13'(r_s2_dy - 13'd1);
        if (r_s2_dy == 13'd0) begin
            n_s3_leaps = 11'd0;
        end else begin
            n_s3_leaps = 11'(w_p[12:2] - 11'(r_s2_pq) + 11'(r_s2_pq[6:2]) + 11'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_err    <= r_s2_err;
        r_s3_leap   <= n_s3_leap;
        r_s3_leaps  <= n_s3_leaps;
        r_s3_d365   <= r_s2_d365;
        r_s3_mo     <= r_s2_mo;
        r_s3_dd     <= r_s2_dd;
        r_s3_hh     <= r_s2_hh;
        r_s3_mi     <= r_s2_mi;
        r_s3_ss     <= r_s2_ss;
        r_s3_yr     <= r_s2_yr;
        r_s3_secs   <= r_s2_secs;
        r_s3_mstart <= r_s2_mstart;
        r_s3_mdays  <= r_s2_mdays;
    end

    // ---- stage 4: day check and day count
    logic               r_s4_v;
    ddcc_pkg::t_result  r_s4_res;
    ddcc_pkg::t_result  n_s4_res;
    logic [4:0]         w_mlen;
    logic               w_err;
    logic               w_after_feb;

    always_comb begin
        w_mlen      = 5'(r_s3_mdays + 5'((r_s3_mo == ddcc_pkg::MONTH_FEB) && r_s3_leap));
        w_err       = r_s3_err || (r_s3_dd == 5'd0) || (r_s3_dd > w_mlen);
        w_after_feb = (r_s3_mo > ddcc_pkg::MONTH_FEB) && r_s3_leap;
        n_s4_res    = '0;
        if (w_err) begin
            n_s4_res.range_error = 1'b1;
        end else begin
            n_s4_res.days    = 22'(r_s3_d365 + 22'(r_s3_leaps) + 22'(r_s3_mstart) +
                                   22'(r_s3_dd) - 22'd1 + 22'(w_after_feb));
            n_s4_res.seconds = r_s3_secs;
            n_s4_res.year    = r_s3_yr;
            n_s4_res.month   = r_s3_mo;
            n_s4_res.day     = r_s3_dd;
            n_s4_res.hour    = r_s3_hh;
            n_s4_res.minute  = r_s3_mi;
            n_s4_res.second  = r_s3_ss;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else begin
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_res <= n_s4_res;
    end

    // ---- delay line to the common depth
    logic              r_dly_v   [DLY];
    ddcc_pkg::t_result r_dly_res [DLY];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DLY; i++) begin
                r_dly_v[i] <= 1'b0;
            end
        end else begin
            r_dly_v[0] <= r_s4_v;
            for (int i = 1; i < DLY; i++) begin
                r_dly_v[i] <= r_dly_v[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dly_res[0] <= r_s4_res;
        for (int i = 1; i < DLY; i++) begin
            r_dly_res[i] <= r_dly_res[i-1];
        end
    end

    assign o_valid  = r_dly_v[DLY-1];
    assign o_result = r_dly_res[DLY-1];

endmodule

`default_nettype wire

FILE: src/ddcc_to_date.sv
// Day count to date and time: seven stages taking the count apart by
// 400-year, century, 4-year and year cycles, then a month search. Uses ddcc_pkg.
`default_nettype none

module ddcc_to_date (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic [21:0]        i_days,
    input  wire logic [16:0]        i_seconds,
    output logic                    o_valid,
    output ddcc_pkg::t_result       o_result
);

    // Exact constant division: x / D = (x * M) >> K, M = ceil(2^K / D)
    localparam int unsigned K400Y = 40;
    localparam logic [22:0] M400Y = 23'(((64'd1 << K400Y) + 64'd146096) / 64'd146097);
    localparam int unsigned K3600 = 29;
    localparam logic [17:0] M3600 = 18'(((64'd1 << K3600) + 64'd3599) / 64'd3600);
    localparam int unsigned K60   = 18;
    localparam logic [12:0] M60   = 13'(((64'd1 << K60) + 64'd59) / 64'd60);
    localparam int unsigned K4Y   = 27;
    localparam logic [16:0] M4Y   = 17'(((64'd1 << K4Y) + 64'd1460) / 64'd1461);

    // ---- stage 1: range check, 400-year cycle and hour estimates
    logic        r_s1_v;
    logic        r_s1_err;
    logic [21:0] r_s1_sd;
    logic [16:0] r_s1_sx;
    logic [4:0]  r_s1_c400;
    logic [5:0]  r_s1_hour;
    logic [44:0] w_c400_prod;
    logic [34:0] w_hour_prod;

    always_comb begin
        w_c400_prod = 45'(i_days) * 45'(M400Y);
        w_hour_prod = 35'(i_seconds) * 35'(M3600);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_err  <= (i_days > ddcc_pkg::DAYS_MAX) || (i_seconds >= ddcc_pkg::SECS_DAY);
        r_s1_sd   <= i_days;
        r_s1_sx   <= i_seconds;
        r_s1_c400 <= w_c400_prod[K400Y +: 5];
        r_s1_hour <= w_hour_prod[K3600 +: 6];
    end

    // ---- stage 2: remainders
    logic        r_s2_v;
    logic        r_s2_err;
    logic [21:0] r_s2_sd;
    logic [16:0] r_s2_sx;
    logic [4:0]  r_s2_c400;
    logic [5:0]  r_s2_hour;
    logic [17:0] r_s2_r1;
    logic [11:0] r_s2_srem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_err  <= r_s1_err;
        r_s2_sd   <= r_s1_sd;
        r_s2_sx   <= r_s1_sx;
        r_s2_c400 <= r_s1_c400;
        r_s2_hour <= r_s1_hour;
        r_s2_r1   <= 18'(r_s1_sd - 22'(22'(r_s1_c400) * 22'd146097));
        r_s2_srem <= 12'(r_s1_sx - 17'(17'(r_s1_hour) * 17'd3600));
    end

    // ---- stage 3: century; minute estimate
    // First century of the cycle holds 36525 days. For later ones the count
    // is moved up by one so that blocks of 1461 days line up.
    logic        r_s3_v;
    logic        r_s3_err;
    logic [21:0] r_s3_sd;
    logic [16:0] r_s3_sx;
    logic [4:0]  r_s3_c400;
    logic [5:0]  r_s3_hour;
    logic [1:0]  r_s3_c;
    logic [15:0] r_s3_t;
    logic [5:0]  r_s3_min;
    logic [11:0] r_s3_srem;
    logic [1:0]  n_s3_c;
    logic [17:0] w_off;
    logic [24:0] w_min_prod;

    always_comb begin
        n_s3_c = 2'(2'(r_s2_r1 >= 18'd36525) + 2'(r_s2_r1 >= 18'd73049) +
                    2'(r_s2_r1 >= 18'd109573));
        case (n_s3_c)
            2'd1:    w_off = 18'd36524;
            2'd2:    w_off = 18'd73048;
            2'd3:    w_off = 18'd109572;
            default: w_off = 18'd0;
        endcase
        w_min_prod = 25'(r_s2_srem) * 25'(M60);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_err  <= r_s2_err;
        r_s3_sd   <= r_s2_sd;
        r_s3_sx   <= r_s2_sx;
        r_s3_c400 <= r_s2_c400;
        r_s3_hour <= r_s2_hour;
        r_s3_c    <= n_s3_c;
        r_s3_t    <= 16'(r_s2_r1 - w_off);
        r_s3_min  <= w_min_prod[K60 +: 6];
        r_s3_srem <= r_s2_srem;
    end

    // ---- stage 4: 4-year block estimate; second of the minute
    logic        r_s4_v;
    logic        r_s4_err;
    logic [21:0] r_s4_sd;
    logic [16:0] r_s4_sx;
    logic [4:0]  r_s4_c400;
    logic [5:0]  r_s4_hour;
    logic [1:0]  r_s4_c;
    logic [15:0] r_s4_t;
    logic [4:0]  r_s4_q;
    logic [5:0]  r_s4_min;
    logic [5:0]  r_s4_sec;
    logic [32:0] w_q_prod;

    always_comb begin
        w_q_prod = 33'(r_s3_t) * 33'(M4Y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else begin
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_err  <= r_s3_err;
        r_s4_sd   <= r_s3_sd;
        r_s4_sx   <= r_s3_sx;
        r_s4_c400 <= r_s3_c400;
        r_s4_hour <= r_s3_hour;
        r_s4_c    <= r_s3_c;
        r_s4_t    <= r_s3_t;
        r_s4_q    <= w_q_prod[K4Y +: 5];
        r_s4_min  <= r_s3_min;
        r_s4_sec  <= 6'(r_s3_srem - 12'(12'(r_s3_min) * 12'd60));
    end

    // ---- stage 5: day within the 4-year block
    // Block 0 of a non-first century has no leap year; undo the shift there.
    logic        r_s5_v;
    logic        r_s5_err;
    logic [21:0] r_s5_sd;
    logic [16:0] r_s5_sx;
    logic [4:0]  r_s5_c400;
    logic [5:0]  r_s5_hour;
    logic [1:0]  r_s5_c;
    logic [4:0]  r_s5_q;
    logic [5:0]  r_s5_min;
    logic [5:0]  r_s5_sec;
    logic [10:0] r_s5_r3;
    logic        r_s5_fl;
    logic        n_s5_fl;

    always_comb begin
        n_s5_fl = !((r_s4_c != 2'd0) && (r_s4_q == 5'd0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v <= 1'b0;
        end else begin
            r_s5_v <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_err  <= r_s4_err;
        r_s5_sd   <= r_s4_sd;
        r_s5_sx   <= r_s4_sx;
        r_s5_c400 <= r_s4_c400;
        r_s5_hour <= r_s4_hour;
        r_s5_c    <= r_s4_c;
        r_s5_q    <= r_s4_q;
        r_s5_min  <= r_s4_min;
        r_s5_sec  <= r_s4_sec;
        r_s5_fl   <= n_s5_fl;
        r_s5_r3   <= 11'(r_s4_t - 16'(16'(r_s4_q) * 16'd1461) - 16'(!n_s5_fl));
    end

    // ---- stage 6: year within the block, year number, leap flag
    logic        r_s6_v;
    logic        r_s6_err;
    logic [21:0] r_s6_sd;
    logic [16:0] r_s6_sx;
    logic [5:0]  r_s6_hour;
    logic [5:0]  r_s6_min;
    logic [5:0]  r_s6_sec;
    logic [8:0]  r_s6_r4;
    logic        r_s6_leap;
    logic [13:0] r_s6_year;
    logic [10:0] w_b1;
    logic [10:0] w_b2;
    logic [10:0] w_b3;
    logic [1:0]  w_yi;
    logic [10:0] w_ybase;

    always_comb begin
        // first year of the block has 366 days when leap
        w_b1 = r_s5_fl ? 11'd366  : 11'd365;
        w_b2 = r_s5_fl ? 11'd731  : 11'd730;
        w_b3 = r_s5_fl ? 11'd1096 : 11'd1095;
        w_yi = 2'(2'(r_s5_r3 >= w_b1) + 2'(r_s5_r3 >= w_b2) + 2'(r_s5_r3 >= w_b3));
        case (w_yi)
            2'd1:    w_ybase = w_b1;
            2'd2:    w_ybase = w_b2;
            2'd3:    w_ybase = w_b3;
            default: w_ybase = 11'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_v <= 1'b0;
        end else begin
            r_s6_v <= r_s5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s6_err  <= r_s5_err;
        r_s6_sd   <= r_s5_sd;
        r_s6_sx   <= r_s5_sx;
        r_s6_hour <= r_s5_hour;
        r_s6_min  <= r_s5_min;
        r_s6_sec  <= r_s5_sec;
        r_s6_r4   <= 9'(r_s5_r3 - w_ybase);
        r_s6_leap <= r_s5_fl && (w_yi == 2'd0);
        r_s6_year <= 14'(ddcc_pkg::YEAR_BASE + 14'(14'(r_s5_c400) * 14'd400) +
                         14'(14'(r_s5_c) * 14'd100) + 14'(14'(r_s5_q) * 14'd4) +
                         14'(w_yi));
    end

    // ---- stage 7: month search, result assembly
    logic               r_s7_v;
    ddcc_pkg::t_result  r_s7_res;
    ddcc_pkg::t_result  n_s7_res;
    logic [3:0]         w_mon;
    logic [8:0]         w_base;

    always_comb begin
        logic [8:0] st;
        w_mon  = 4'd1;
        w_base = 9'd0;
        st     = 9'd0;
        for (int i = 1; i < int'(ddcc_pkg::MONTHS); i++) begin
            st = 9'(ddcc_pkg::month_start_f(4'(i)) + 9'(r_s6_leap && (i >= 2)));
            if (r_s6_r4 >= st) begin
                w_mon  = 4'(i + 1);
                w_base = st;
            end
        end
        n_s7_res = '0;
        if (r_s6_err) begin
            n_s7_res.range_error = 1'b1;
        end else begin
            n_s7_res.days    = r_s6_sd;
            n_s7_res.seconds = r_s6_sx;
            n_s7_res.year    = r_s6_year;
            n_s7_res.month   = w_mon;
            n_s7_res.day     = 5'(r_s6_r4 - w_base + 9'd1);
            n_s7_res.hour    = 5'(r_s6_hour);
            n_s7_res.minute  = r_s6_min;
            n_s7_res.second  = r_s6_sec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_v <= 1'b0;
        end else begin
            r_s7_v <= r_s6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s7_res <= n_s7_res;
    end

    assign o_valid  = r_s7_v;
    assign o_result = r_s7_res;

endmodule

`default_nettype wire

FILE: src/date_day_count_converter.sv
// Top level of the date / day-count converter: both conversion pipelines
// and the output register. Depends on ddcc_pkg, ddcc_to_serial, ddcc_to_date.
`default_nettype none

// Converts a Gregorian date and time (years 2000 to 9999) into days since
// 1 Jan 2000 plus second of the day (i_operation = 0), or back (= 1).
// A transfer is taken on every clock edge with start high; busy is always low,
// so one item per clock is sustained indefinitely. Each result is shown for one
// cycle, marked by o_valid; results come back in order and the receiver cannot
// hold them off, so it must take every strobe. The path to a result is as deep
// as the seven pipeline stages of the reverse conversion (400-year, century,
// 4-year and year cycles, then the month search) plus the output register; the
// forward path is padded to the same depth. Only the fields the chosen
// operation uses are checked: a field out of range gives o_range_error = 1
// with every other field zero. A good result carries both forms: the converted
// one and an echo of the input. No state outlives an item; reset only clears
// the valid bits.

module date_day_count_converter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_operation,
    input  wire logic [13:0] i_date_year,
    input  wire logic [3:0]  i_date_month,
    input  wire logic [4:0]  i_date_day,
    input  wire logic [4:0]  i_time_hour,
    input  wire logic [5:0]  i_time_minute,
    input  wire logic [5:0]  i_time_second,
    input  wire logic [21:0] i_serial_days,
    input  wire logic [16:0] i_serial_seconds,
    output logic             o_valid,
    output logic [21:0]      o_result_days,
    output logic [16:0]      o_result_seconds,
    output logic [13:0]      o_result_year,
    output logic [3:0]       o_result_month,
    output logic [4:0]       o_result_day,
    output logic [4:0]       o_result_hour,
    output logic [5:0]       o_result_minute,
    output logic [5:0]       o_result_second,
    output logic             o_range_error
);

    logic              w_fwd_in_v;
    logic              w_rev_in_v;
    logic              w_fwd_v;
    logic              w_rev_v;
    ddcc_pkg::t_result w_fwd_res;
    ddcc_pkg::t_result w_rev_res;
    logic              r_out_v;
    ddcc_pkg::t_result r_out;

    // pipelined throughout, never stalls
    assign busy = 1'b0;

    // steer each transfer into the pipe for its direction
    assign w_fwd_in_v = start && (i_operation == ddcc_pkg::OP_TO_SERIAL);
    assign w_rev_in_v = start && (i_operation == ddcc_pkg::OP_TO_DATE);

    ddcc_to_serial u_to_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_fwd_in_v),
        .i_year   (i_date_year),
        .i_month  (i_date_month),
        .i_day    (i_date_day),
        .i_hour   (i_time_hour),
        .i_minute (i_time_minute),
        .i_second (i_time_second),
        .o_valid  (w_fwd_v),
        .o_result (w_fwd_res)
    );

    ddcc_to_date u_to_date (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_rev_in_v),
        .i_days    (i_serial_days),
        .i_seconds (i_serial_seconds),
        .o_valid   (w_rev_v),
        .o_result  (w_rev_res)
    );

    // Both pipes have equal depth, so at most one of them is valid per cycle
    // and order is kept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= w_fwd_v || w_rev_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= w_fwd_v ? w_fwd_res : w_rev_res;
    end

    assign o_valid          = r_out_v;
    assign o_result_days    = r_out.days;
    assign o_result_seconds = r_out.seconds;
    assign o_result_year    = r_out.year;
    assign o_result_month   = r_out.month;
    assign o_result_day     = r_out.day;
    assign o_result_hour    = r_out.hour;
    assign o_result_minute  = r_out.minute;
    assign o_result_second  = r_out.second;
    assign o_range_error    = r_out.range_error;

endmodule

`default_nettype wire

FILE: src/ddcc_checker.sv
// Port-level checks for the date / day-count converter, bound to the top level.
// Depends on ddcc_pkg.
`default_nettype none

module ddcc_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic        i_operation,
    input  wire logic [13:0] i_date_year,
    input  wire logic        o_valid,
    input  wire logic [21:0] o_result_days,
    input  wire logic [16:0] o_result_seconds,
    input  wire logic [13:0] o_result_year,
    input  wire logic [3:0]  o_result_month,
    input  wire logic [4:0]  o_result_day,
    input  wire logic        o_range_error
);

    localparam int unsigned LAT = ddcc_pkg::LATENCY;

    // no stale strobes straight out of reset
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("strobe in the cycle after reset");

    // fixed latency, nothing lost
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LAT o_valid)
        else $error("transfer without a result after the pipeline latency");

    // nothing invented
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without a matching transfer");

    // error results are blank, good results stay in range
    a_result_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_range_error ?
            (o_result_days == 22'd0 && o_result_seconds == 17'd0 &&
             o_result_year == 14'd0 && o_result_month == 4'd0 && o_result_day == 5'd0) :
            (o_result_month >= 4'd1 && o_result_month <= ddcc_pkg::MONTHS &&
             o_result_day != 5'd0 && o_result_seconds < ddcc_pkg::SECS_DAY &&
             o_result_year >= ddcc_pkg::YEAR_BASE && o_result_year <= ddcc_pkg::YEAR_MAX)))
        else $error("result fields inconsistent with range_error");

    // a good date-to-serial result echoes its year
    a_year_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_operation == ddcc_pkg::OP_TO_SERIAL) |->
            ##LAT (o_range_error || o_result_year == $past(i_date_year, LAT)))
        else $error("year not echoed");

endmodule

bind date_day_count_converter ddcc_checker u_ddcc_checker (.*);

`default_nettype wire

FILE: bench/date_day_count_converter_tb.sv
// Self-checking bench for date_day_count_converter: directed calendar corners, then
// random dates, serial counts and noise, checked against an in-bench calendar model.
// Depends on ddcc_pkg and date_day_count_converter only.
`timescale 1ns / 100ps

module date_day_count_converter_tb;

    localparam int unsigned RANDOM_ITEMS = 600;
    localparam int unsigned QUIET_TAIL   = 80;       // last items go back to back
    localparam int unsigned DAYS_400Y    = 146097;   // one full Gregorian cycle

    // One input transfer; hold_for_drain makes the sender wait for an empty pipe first
    typedef struct {
        logic        op;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [21:0] sdays;
        logic [16:0] ssecs;
        bit          hold_for_drain;
    } t_xfer;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        start            = 1'b0;
    logic        i_operation      = ddcc_pkg::OP_TO_SERIAL;
    logic [13:0] i_date_year      = '0;
    logic [3:0]  i_date_month     = '0;
    logic [4:0]  i_date_day       = '0;
    logic [4:0]  i_time_hour      = '0;
    logic [5:0]  i_time_minute    = '0;
    logic [5:0]  i_time_second    = '0;
    logic [21:0] i_serial_days    = '0;
    logic [16:0] i_serial_seconds = '0;
    logic        busy;
    logic        o_valid;
    logic [21:0] o_result_days;
    logic [16:0] o_result_seconds;
    logic [13:0] o_result_year;
    logic [3:0]  o_result_month;
    logic [4:0]  o_result_day;
    logic [4:0]  o_result_hour;
    logic [5:0]  o_result_minute;
    logic [5:0]  o_result_second;
    logic        o_range_error;

    t_xfer             pending_q[$];     // items still to be sent
    ddcc_pkg::t_result converted_q[$];   // predicted results, oldest first
    t_xfer             on_ports;         // item currently presented to the block
    bit                handed_over = 1'b0;
    int unsigned       idle_left   = 0;
    int unsigned       fail_count  = 0;

    date_day_count_converter uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Calendar model
    // ------------------------------------------------------------------

    function automatic bit is_leap(input int unsigned y);
        return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
    endfunction

    function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
        case (m)
            2:             return is_leap(y) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // Days from 1 Jan 2000 to the given date. Leap years counted in closed form:
    // 484 is the count of 4/100/400 multiples up to 1999, so 2000 itself adds one.
    function automatic int unsigned date_to_days(input int unsigned y, input int unsigned m,
                                                 input int unsigned d);
        int unsigned n, k;
        n = 365 * (y - 2000) + ((y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400) - 484 + d - 1;
        for (k = 1; k < m; k++)
            n += month_length(y, k);
        return n;
    endfunction

    // Expected result of one transfer. The reverse direction walks whole years
    // inside the 400-year cycle and then whole months: slow but plainly exact,
    // so it checks the block's cycle decomposition independently.
    function automatic ddcc_pkg::t_result convert_calendar(input t_xfer it);
        ddcc_pkg::t_result r;
        int unsigned       rem, yr, mo;
        r = '0;
        if (it.op == ddcc_pkg::OP_TO_SERIAL) begin
            // only the date and time fields matter here; the serial ones are ignored
            if (it.year < ddcc_pkg::YEAR_BASE || it.year > ddcc_pkg::YEAR_MAX ||
                it.month < 1 || it.month > ddcc_pkg::MONTHS ||
                it.hour > 23 || it.minute > 59 || it.second > 59 || it.day == 0 ||
                it.day > month_length(it.year, it.month)) begin
                r.range_error = 1'b1;
            end else begin
                r.days    = 22'(date_to_days(it.year, it.month, it.day));
                r.seconds = 17'(it.hour * 3600 + it.minute * 60 + it.second);
                r.year    = it.year;
                r.month   = it.month;
                r.day     = it.day;
                r.hour    = it.hour;
                r.minute  = it.minute;
                r.second  = it.second;
            end
        end else begin
            if (it.sdays > ddcc_pkg::DAYS_MAX || it.ssecs >= ddcc_pkg::SECS_DAY) begin
                r.range_error = 1'b1;
            end else begin
                yr  = ddcc_pkg::YEAR_BASE + 400 * (it.sdays / DAYS_400Y);
                rem = it.sdays % DAYS_400Y;
                while (rem >= (is_leap(yr) ? 366 : 365)) begin
                    rem -= is_leap(yr) ? 366 : 365;
                    yr++;
                end
                mo = 1;
                while (rem >= month_length(yr, mo)) begin
                    rem -= month_length(yr, mo);
                    mo++;
                end
                r.days    = it.sdays;
                r.seconds = it.ssecs;
                r.year    = 14'(yr);
                r.month   = 4'(mo);
                r.day     = 5'(rem + 1);
                r.hour    = 5'(it.ssecs / 3600);
                r.minute  = 6'((it.ssecs % 3600) / 60);
                r.second  = 6'(it.ssecs % 60);
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers: unused fields always carry full-width random values
    // ------------------------------------------------------------------

    function automatic t_xfer random_fields();
        t_xfer it;
        it.op             = 1'($urandom_range(0, 1));
        it.year           = 14'($urandom);
        it.month          = 4'($urandom);
        it.day            = 5'($urandom);
        it.hour           = 5'($urandom);
        it.minute         = 6'($urandom);
        it.second         = 6'($urandom);
        it.sdays          = 22'($urandom);
        it.ssecs          = 17'($urandom);
        it.hold_for_drain = 1'b0;
        return it;
    endfunction

    task automatic queue_date(input int unsigned y, input int unsigned m, input int unsigned d,
                              input int unsigned h, input int unsigned mi, input int unsigned s);
        t_xfer it;
        it        = random_fields();
        it.op     = ddcc_pkg::OP_TO_SERIAL;
        it.year   = 14'(y);
        it.month  = 4'(m);
        it.day    = 5'(d);
        it.hour   = 5'(h);
        it.minute = 6'(mi);
        it.second = 6'(s);
        pending_q.push_back(it);
    endtask

    task automatic queue_serial(input int unsigned days, input int unsigned secs);
        t_xfer it;
        it       = random_fields();
        it.op    = ddcc_pkg::OP_TO_DATE;
        it.sdays = 22'(days);
        it.ssecs = 17'(secs);
        pending_q.push_back(it);
    endtask

    task automatic check_field(input string name, input logic [21:0] want,
                               input logic [21:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: inputs change on the falling edge. A new item goes out once the
    // previous one was taken; idle bursts come in alternate stretches of 64
    // items, never in the quiet tail. An item flagged hold_for_drain waits until
    // every predicted result has come back.
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (i_rst_n && (!start || handed_over)) begin
            handed_over = 1'b0;
            if (idle_left != 0) begin
                idle_left--;
                start <= 1'b0;
            end else if (pending_q.size() == 0 ||
                         (pending_q[0].hold_for_drain && converted_q.size() != 0)) begin
                start <= 1'b0;
            end else if (pending_q.size() > QUIET_TAIL && (pending_q.size() / 64) % 2 == 1 &&
                         $urandom_range(0, 3) == 0) begin
                idle_left = $urandom_range(1, 8) - 1;   // this cycle is the first idle one
                start <= 1'b0;
            end else begin
                on_ports = pending_q.pop_front();
                i_operation      <= on_ports.op;
                i_date_year      <= on_ports.year;
                i_date_month     <= on_ports.month;
                i_date_day       <= on_ports.day;
                i_time_hour      <= on_ports.hour;
                i_time_minute    <= on_ports.minute;
                i_time_second    <= on_ports.second;
                i_serial_days    <= on_ports.sdays;
                i_serial_seconds <= on_ports.ssecs;
                start            <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: on the rising edge, check any strobed result against the oldest
    // prediction first, then record the transfer taken at this same edge.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : monitor
        ddcc_pkg::t_result want;
        if (i_rst_n) begin
            if (o_valid !== 1'b0) begin
                if (converted_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result strobe with nothing outstanding", $realtime);
                end else begin
                    want = converted_q.pop_front();
                    check_field("days",        want.days,             o_result_days);
                    check_field("seconds",     22'(want.seconds),     22'(o_result_seconds));
                    check_field("year",        22'(want.year),        22'(o_result_year));
                    check_field("month",       22'(want.month),       22'(o_result_month));
                    check_field("day",         22'(want.day),         22'(o_result_day));
                    check_field("hour",        22'(want.hour),        22'(o_result_hour));
                    check_field("minute",      22'(want.minute),      22'(o_result_minute));
                    check_field("second",      22'(want.second),      22'(o_result_second));
                    check_field("range_error", 22'(want.range_error), 22'(o_range_error));
                end
            end
            if (start && busy === 1'b0) begin
                converted_q.push_back(convert_calendar(on_ports));
                handed_over = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin : stimulus
        int unsigned n, yr, mo, dy, len, pick, days, secs, k;

        // Directed: first and last valid instants, leap day in 400/100/4-year
        // years, every way a date field can be out of range
        queue_date(2000, 1, 1, 0, 0, 0);
        queue_date(9999, 12, 31, 23, 59, 59);
        queue_date(2000, 2, 29, 12, 30, 30);
        queue_date(2100, 2, 29, 1, 2, 3);       // century, not leap
        queue_date(2100, 3, 1, 4, 5, 6);
        queue_date(2004, 2, 29, 7, 8, 9);
        queue_date(2001, 2, 29, 0, 0, 0);
        queue_date(1999, 12, 31, 0, 0, 0);
        queue_date(10000, 1, 1, 0, 0, 0);
        queue_date(16383, 15, 31, 31, 63, 63);  // every field at its top
        queue_date(2024, 0, 10, 0, 0, 0);
        queue_date(2024, 13, 1, 0, 0, 0);
        queue_date(2024, 4, 31, 0, 0, 0);
        queue_date(2024, 6, 0, 0, 0, 0);
        queue_date(2024, 5, 5, 24, 0, 0);
        queue_date(2024, 5, 5, 0, 60, 0);
        queue_date(2024, 5, 5, 0, 0, 60);
        // Directed: serial extremes and year / month boundaries
        queue_serial(0, 0);
        queue_serial(ddcc_pkg::DAYS_MAX, ddcc_pkg::SECS_DAY - 1);
        queue_serial(ddcc_pkg::DAYS_MAX + 1, 0);
        queue_serial(4194303, 131071);
        queue_serial(100, ddcc_pkg::SECS_DAY);
        queue_serial(60, 43200);                                // 1 Mar 2000
        queue_serial(366, 1);                                   // 1 Jan 2001
        queue_serial(date_to_days(2100, 3, 1) - 1, 86000);      // 28 Feb 2100
        queue_serial(date_to_days(2400, 2, 29), 3599);

        // Random: mostly valid dates and counts near interesting days, plus noise
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            yr = $urandom_range(2000, 9999);
            case ($urandom_range(0, 7))
                0:       yr = yr - yr % 100;
                1:       yr = 2000 + 400 * $urandom_range(0, 19);
                default: ;
            endcase
            mo  = $urandom_range(1, 12);
            len = month_length(yr, mo);
            case ($urandom_range(0, 5))
                0:       dy = 1;
                1:       dy = len;
                default: dy = $urandom_range(1, len);
            endcase
            pick = $urandom_range(0, 19);
            if (pick < 8) begin
                queue_date(yr, mo, dy, $urandom_range(0, 23), $urandom_range(0, 59),
                           $urandom_range(0, 59));
            end else if (pick < 12) begin
                days = date_to_days(yr, mo, dy);
                if (days != 0 && $urandom_range(0, 1))
                    days--;                             // day before a month start or end
                secs = $urandom_range(0, 1) ? ddcc_pkg::SECS_DAY - 1 : $urandom_range(0, 86399);
                queue_serial(days, secs);
            end else if (pick < 15) begin
                queue_serial($urandom_range(0, ddcc_pkg::DAYS_MAX), $urandom_range(0, 86399));
            end else if (pick < 18) begin
                pending_q.push_back(random_fields());
            end else if (pick == 18) begin
                queue_date(yr, mo, len + 1, 0, 0, 0);   // one day past the month's end
            end else begin
                queue_date(yr, mo, dy, $urandom_range(24, 31), $urandom_range(0, 63),
                           $urandom_range(0, 63));
            end
            if (n == 0 || n == RANDOM_ITEMS / 2)
                pending_q[$].hold_for_drain = 1'b1;
        end

        // Reset is held, then released on a falling edge
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || start)
            @(negedge i_clk);
        for (k = 0; k < 4 * ddcc_pkg::LATENCY && converted_q.size() != 0; k++)
            @(negedge i_clk);
        repeat (ddcc_pkg::LATENCY + 4) @(negedge i_clk);   // catch any stray strobe
        if (converted_q.size() != 0) begin
            fail_count += converted_q.size();
            $display("%0d predicted results never arrived", converted_q.size());
        end

        if (fail_count == 0)
            $display("date_day_count_converter_tb: clean");
        else
            $display("date_day_count_converter_tb: errors");
        $finish;
    end

    // Watchdog: the slowest legal run is well under a tenth of this
    initial begin
        #2000000;
        $display("date_day_count_converter_tb: errors");
        $finish;
    end

endmodule

FILE: files.f
src/ddcc_pkg.sv
src/ddcc_to_serial.sv
src/ddcc_to_date.sv
src/date_day_count_converter.sv
src/ddcc_checker.sv
bench/date_day_count_converter_tb.sv
